FILE: design/tbrv_pkg.sv
package tbrv_pkg;

    // Access codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_UNWRITTEN = 2'd2;

    localparam int TASK_ID_W = 3;

    typedef struct packed {
        logic        operation;
        logic [15:0] address;
        logic [31:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
        logic        write_dropped;
    } t_out_word;

endpackage

FILE: design/tbrv_store.sv
module tbrv_store #(
    parameter int DEPTH = 3072
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [31:0]              i_wdata,
    output logic [31:0]              o_rdata,
    output logic                     o_rvalid,
    output logic                     o_busy
);
    localparam int AW = $clog2(DEPTH);

    logic [31:0]   r_mem [DEPTH];
    logic          r_vmem [DEPTH];
    logic [31:0]   r_rdata;
    logic          r_rvalid;
    logic          r_busy;
    logic [AW-1:0] r_clr_addr;

    // Sweep the valid bits to zero after reset, one word a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Data array: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    // Valid-bit array: the clearing sweep owns the write port while busy
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_vmem[r_clr_addr] <= 1'b0;
        end else if (i_wr_en) begin
            r_vmem[i_addr] <= 1'b1;
        end
        if (i_rd_en) begin
            r_rvalid <= r_vmem[i_addr];
        end
    end

    assign o_rdata  = r_rdata;
    assign o_rvalid = r_rvalid;
    assign o_busy   = r_busy;

endmodule

FILE: design/task_banked_ram_with_valid_bits_top.sv
// Throughput: one word per cycle while neither i_out_stall nor the clear sweep
// stalls it; the translation register and the registered RAM read form a
// two-stage pipeline with one access to each array per cycle.
// Reset: task_id goes to 0 and the first write afterwards is dropped. The valid
// bits are then swept to zero, all PRIVATE_WORDS*TASK_COUNT+SYSTEM_WORDS words
// (3072 by default), while input words are stalled; config writes are taken.
module task_banked_ram_with_valid_bits_top #(
    parameter int PRIVATE_WORDS = 256,
    parameter int TASK_COUNT    = 8,
    parameter int SYSTEM_WORDS  = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tbrv_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tbrv_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_data
);
    import tbrv_pkg::*;

    localparam int SYS_BASE      = PRIVATE_WORDS * TASK_COUNT;
    localparam int TOTAL_WORDS   = SYS_BASE + SYSTEM_WORDS;
    localparam int LOGICAL_WORDS = PRIVATE_WORDS + SYSTEM_WORDS;
    localparam int PA_W          = $clog2(TOTAL_WORDS);

    logic [TASK_ID_W-1:0] r_task_id;
    logic                 r_first_pend;

    logic                 w_accept;
    logic                 w_is_write;
    logic                 w_is_priv;
    logic                 w_range_ok;
    logic                 w_drop;
    logic [PA_W-1:0]      w_phys;

    logic                 r_a_vld;
    logic                 r_a_op;
    logic                 r_a_range_ok;
    logic                 r_a_drop;
    logic [PA_W-1:0]      r_a_phys;
    logic [31:0]          r_a_wdata;

    logic                 r_b_vld;
    logic                 r_b_op;
    logic                 r_b_range_ok;
    logic                 r_b_drop;

    logic                 w_a_adv;
    logic                 w_b_free;
    logic                 w_wr_en;
    logic [31:0]          w_rdata;
    logic                 w_rvalid;
    logic                 w_busy;

    // Handshake: stall input during the clear sweep or when stage A cannot move
    assign w_b_free   = !r_b_vld || !i_out_stall;
    assign w_a_adv    = r_a_vld && w_b_free;
    assign o_in_stall = w_busy || (r_a_vld && !w_b_free);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Translate logical address to physical word
    always_comb begin
        w_is_write = (i_in_word.operation == OP_WRITE);
        w_is_priv  = int'(i_in_word.address) < PRIVATE_WORDS;
        w_range_ok = (int'(i_in_word.address) < LOGICAL_WORDS)
                  && (!w_is_priv || int'(r_task_id) < TASK_COUNT);
        w_drop     = w_is_write && r_first_pend;
        w_phys     = '0;
        if (w_range_ok) begin
            if (w_is_priv) begin
                w_phys = PA_W'(PRIVATE_WORDS * int'(r_task_id) + int'(i_in_word.address));
            end else begin
                w_phys = PA_W'(SYS_BASE + int'(i_in_word.address) - PRIVATE_WORDS);
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_id    <= '0;
            r_first_pend <= 1'b1;
            r_a_vld      <= 1'b0;
            r_b_vld      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_task_id <= i_cfg_data;
            end
            if (w_accept && w_is_write) begin
                r_first_pend <= 1'b0;
            end
            if (w_accept) begin
                r_a_vld <= 1'b1;
            end else if (w_a_adv) begin
                r_a_vld <= 1'b0;
            end
            if (w_a_adv) begin
                r_b_vld <= 1'b1;
            end else if (w_b_free) begin
                r_b_vld <= 1'b0;
            end
        end
    end

    // Stage payloads: hold unless the stage advances
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_op       <= i_in_word.operation;
            r_a_range_ok <= w_range_ok;
            r_a_drop     <= w_drop;
            r_a_phys     <= w_phys;
            r_a_wdata    <= i_in_word.write_data;
        end
        if (w_a_adv) begin
            r_b_op       <= r_a_op;
            r_b_range_ok <= r_a_range_ok;
            r_b_drop     <= r_a_drop;
        end
    end

    assign w_wr_en = w_a_adv && (r_a_op == OP_WRITE) && r_a_range_ok && !r_a_drop;

    tbrv_store #(
        .DEPTH (TOTAL_WORDS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (w_a_adv),
        .i_wr_en  (w_wr_en),
        .i_addr   (r_a_phys),
        .i_wdata  (r_a_wdata),
        .o_rdata  (w_rdata),
        .o_rvalid (w_rvalid),
        .o_busy   (w_busy)
    );

    // Form the result word
    always_comb begin
        o_out_word.write_dropped = r_b_drop;
        o_out_word.read_data     = '0;
        if (r_b_drop) begin
            o_out_word.status = ST_OK;
        end else if (!r_b_range_ok) begin
            o_out_word.status = ST_RANGE;
        end else if (r_b_op == OP_READ && !w_rvalid) begin
            o_out_word.status = ST_UNWRITTEN;
        end else begin
            o_out_word.status = ST_OK;
            if (r_b_op == OP_READ) begin
                o_out_word.read_data = w_rdata;
            end
        end
    end

    assign o_out_valid = r_b_vld;

endmodule

FILE: design/tbrv_checker.sv
module tbrv_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tbrv_pkg::t_out_word o_out_word
);
    import tbrv_pkg::*;

    logic w_in_acc;
    logic w_out_acc;
    logic r_seen_drop;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;

    // Track a delivered dropped write since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_drop <= 1'b0;
        end else if (w_out_acc && o_out_word.write_dropped) begin
            r_seen_drop <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc ##1 !i_out_stall |=> o_out_valid)
        else $error("result word missing two cycles after accept");

    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.write_dropped
        |-> o_out_word.status == ST_OK && o_out_word.read_data == '0)
        else $error("dropped write carries status or data");

    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.read_data != '0 |-> o_out_word.status == ST_OK)
        else $error("nonzero read data with error status");

    a_drop_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && o_out_word.write_dropped |-> !r_seen_drop)
        else $error("more than one write dropped after reset");

endmodule

bind task_banked_ram_with_valid_bits_top tbrv_checker u_tbrv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
